// ===== rtl/bounded_handle_table_checker_defines.svh =====
// Assertion macros shared by the bounded handle table checker RTL.
`ifndef BOUNDED_HANDLE_TABLE_CHECKER_DEFINES_SVH
`define BOUNDED_HANDLE_TABLE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BHTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BHTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bhtc_pkg.sv =====
// Shared types and constants for the bounded handle table checker.
package bhtc_pkg;

  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 4;
  // Sizes are non-negative 32-bit values, so 31 bits hold them.
  localparam int unsigned SIZE_W   = 31;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_ALLOC_RO = 2'd1,
    ACT_SPAN     = 2'd2,
    ACT_CHECK    = 2'd3
  } bhtc_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 4'd0,
    ST_NEG_SIZE       = 4'd1,
    ST_BAD_HANDLE     = 4'd2,
    ST_BAD_SPAN_ARGS  = 4'd3,
    ST_SPAN_OOB       = 4'd4,
    ST_READ_ONLY      = 4'd5,
    ST_ACCESS_OOB     = 4'd6,
    ST_TABLE_FULL     = 4'd7,
    ST_HEAP_EXHAUSTED = 4'd8
  } bhtc_status_e;

  typedef struct packed {
    bhtc_status_e          status;
    logic [HANDLE_W-1:0]   new_handle;
    logic [FIELD_W-1:0]    resolved_address;
  } bhtc_result_t;

endpackage

// ===== rtl/bounded_handle_table_checker.sv =====
// Top level of the bounded handle table checker: control, state and result register.
//
// Requests come in on in_valid_i / in_stall_o with action, handle, offset, length
// and for_write; each request produces exactly one result transaction on
// out_valid_o / out_stall_i carrying status, new_handle and resolved_address.
// A transaction moves at a rising edge where valid is high and stall is low.
// The heap_limit register is written on cfg_valid_i / cfg_ready_o (always ready);
// write it only while no request is in flight.
// The descriptor memory read is issued at the accept edge and registered, as is
// the request; evaluation happens in the next cycle, and the result and the state
// update are registered at the edge where the evaluation stage advances.
// Throughput is one request per cycle while the receiver does not stall: an entry
// appended at an edge is forwarded to a request that reads it at the same edge.
// Reset clears the handle counter to one, the bump pointer to zero, heap_limit to
// all ones and all valid flags; descriptor contents are not cleared, since only
// the entries of handles below the counter are ever used.
// While the receiver stalls, the result register holds; the evaluation stage
// holds its request and in_stall_o rises once both are occupied.

`include "bounded_handle_table_checker_defines.svh"

module bounded_handle_table_checker import bhtc_pkg::*; #(
  parameter int unsigned NUM_HANDLES = 256,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [FIELD_W-1:0]        cfg_data_i,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [HANDLE_W-1:0]       handle_i,
  input  logic signed [FIELD_W-1:0] offset_i,
  input  logic signed [FIELD_W-1:0] length_i,
  input  logic                      for_write_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [HANDLE_W-1:0]       new_handle_o,
  output logic [FIELD_W-1:0]        resolved_address_o
);

  localparam int unsigned HW      = $clog2(NUM_HANDLES);
  localparam int unsigned NHW     = $clog2(NUM_HANDLES + 1);
  localparam int unsigned ENTRY_W = ADDR_BITS + SIZE_W + 1;

  // control state
  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [NHW-1:0]     next_handle_q;
  logic [FIELD_W-1:0] next_free_q;
  logic [FIELD_W-1:0] heap_limit_q;

  // request register (payload)
  logic [1:0]                action_q;
  logic [HANDLE_W-1:0]       handle_q;
  logic signed [FIELD_W-1:0] offset_q;
  logic signed [FIELD_W-1:0] length_q;
  logic                      for_write_q;

  bhtc_result_t result_d, result_q;

  logic                 in_accept;
  logic                 advance;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [ADDR_BITS-1:0] app_base;
  logic [SIZE_W-1:0]    app_size;
  logic                 app_ro;
  logic                 append;
  logic                 bump;
  logic [FIELD_W-1:0]   next_free_d;
  logic                 wr_en;

  // Advance the evaluation stage when the result register is empty or draining.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = advance && append;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      next_handle_q <= NHW'(1);
      next_free_q   <= '0;
      heap_limit_q  <= '1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        heap_limit_q <= cfg_data_i;
      end
      if (wr_en) begin
        next_handle_q <= next_handle_q + NHW'(1);
      end
      if (advance && bump) begin
        next_free_q <= next_free_d;
      end
    end
  end

  // Capture the request; hold it while the stage is stalled.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q    <= action_i;
      handle_q    <= handle_i;
      offset_q    <= offset_i;
      length_q    <= length_i;
      for_write_q <= for_write_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  bhtc_table #(
    .DEPTH  (NUM_HANDLES),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (HW'(next_handle_q)),
    .wr_data_i ({app_base, app_size, app_ro}),
    .rd_en_i   (in_accept),
    .rd_addr_i (HW'(handle_i)),
    .rd_data_o (rd_entry)
  );

  bhtc_eval #(
    .NUM_HANDLES (NUM_HANDLES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_eval (
    .action_i      (action_q),
    .handle_i      (handle_q),
    .offset_i      (offset_q),
    .length_i      (length_q),
    .for_write_i   (for_write_q),
    .ent_base_i    (rd_entry[ENTRY_W-1 -: ADDR_BITS]),
    .ent_size_i    (rd_entry[SIZE_W:1]),
    .ent_ro_i      (rd_entry[0]),
    .next_handle_i (next_handle_q),
    .next_free_i   (next_free_q),
    .heap_limit_i  (heap_limit_q),
    .result_o      (result_d),
    .append_o      (append),
    .app_base_o    (app_base),
    .app_size_o    (app_size),
    .app_ro_o      (app_ro),
    .bump_o        (bump),
    .next_free_o   (next_free_d)
  );

  assign out_valid_o        = out_valid_q;
  assign status_o           = result_q.status;
  assign new_handle_o       = result_q.new_handle;
  assign resolved_address_o = result_q.resolved_address;

  // The handle counter stays between one and the table depth.
`BHTC_ASSERT_IMP(a_nh_range, clk_i, rst_ni, 1'b1, (next_handle_q >= NHW'(1)) && (next_handle_q <= NHW'(NUM_HANDLES)), "handle counter out of range")
  // An append moves the counter by exactly one.
`BHTC_ASSERT_NXT(a_nh_step, clk_i, rst_ni, wr_en, next_handle_q == $past(next_handle_q) + NHW'(1), "handle counter did not step on append")
  // The bump pointer only grows.
`BHTC_ASSERT_NXT(a_free_mono, clk_i, rst_ni, 1'b1, next_free_q >= $past(next_free_q), "bump pointer moved backward")
  // A failed request carries neither a new handle nor an address.
`BHTC_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid_q && (result_q.status != ST_OK), (result_q.new_handle == '0) && (result_q.resolved_address == '0), "failed result carries data")

endmodule

// ===== rtl/bhtc_table.sv =====
// Descriptor memory: one write port, one registered read port with write bypass.
module bhtc_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Forward the entry written at the same edge so a back-to-back reader sees it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bhtc_eval.sv =====
// Request evaluation: error priority, append decision and result fields.
module bhtc_eval import bhtc_pkg::*; #(
  parameter int unsigned NUM_HANDLES = 256,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic [1:0]                         action_i,
  input  logic [HANDLE_W-1:0]                handle_i,
  input  logic signed [FIELD_W-1:0]          offset_i,
  input  logic signed [FIELD_W-1:0]          length_i,
  input  logic                               for_write_i,
  input  logic [ADDR_BITS-1:0]               ent_base_i,
  input  logic [SIZE_W-1:0]                  ent_size_i,
  input  logic                               ent_ro_i,
  input  logic [$clog2(NUM_HANDLES+1)-1:0]   next_handle_i,
  input  logic [FIELD_W-1:0]                 next_free_i,
  input  logic [FIELD_W-1:0]                 heap_limit_i,
  output bhtc_result_t                       result_o,
  output logic                               append_o,
  output logic [ADDR_BITS-1:0]               app_base_o,
  output logic [SIZE_W-1:0]                  app_size_o,
  output logic                               app_ro_o,
  output logic                               bump_o,
  output logic [FIELD_W-1:0]                 next_free_o
);

  localparam int unsigned NHW = $clog2(NUM_HANDLES + 1);

  bhtc_action_e         act;
  logic                 off_neg;
  logic                 len_neg;
  logic                 full;
  logic                 hvalid;
  logic [FIELD_W:0]     alloc_end;
  logic [FIELD_W-1:0]   span_end;
  logic                 span_oob;
  logic [ADDR_BITS-1:0] sum_base;

  assign act     = bhtc_action_e'(action_i);
  assign off_neg = offset_i[FIELD_W-1];
  assign len_neg = length_i[FIELD_W-1];
  assign full    = (next_handle_i == NHW'(NUM_HANDLES));
  assign hvalid  = (handle_i != '0) && (32'(handle_i) < 32'(next_handle_i));

  assign alloc_end = {1'b0, next_free_i} + (FIELD_W+1)'($unsigned(length_i));
  assign span_end  = {1'b0, offset_i[SIZE_W-1:0]} + {1'b0, length_i[SIZE_W-1:0]};
  assign span_oob  = span_end > {1'b0, ent_size_i};
  // Wrap at the address width, as the descriptor base does.
  assign sum_base  = ent_base_i + ADDR_BITS'($unsigned(offset_i));

  always_comb begin
    result_o.status           = ST_OK;
    result_o.new_handle       = '0;
    result_o.resolved_address = '0;
    append_o    = 1'b0;
    app_base_o  = sum_base;
    app_size_o  = length_i[SIZE_W-1:0];
    app_ro_o    = ent_ro_i;
    bump_o      = 1'b0;
    next_free_o = alloc_end[FIELD_W-1:0];
    case (act)
      ACT_ALLOC, ACT_ALLOC_RO: begin
        app_base_o = ADDR_BITS'(next_free_i);
        app_ro_o   = (act == ACT_ALLOC_RO);
        if (len_neg) begin
          result_o.status = ST_NEG_SIZE;
        end else if (full) begin
          result_o.status = ST_TABLE_FULL;
        end else if (alloc_end > {1'b0, heap_limit_i}) begin
          result_o.status = ST_HEAP_EXHAUSTED;
        end else begin
          result_o.new_handle = HANDLE_W'(next_handle_i);
          append_o = 1'b1;
          bump_o   = 1'b1;
        end
      end
      ACT_SPAN: begin
        if (!hvalid) begin
          result_o.status = ST_BAD_HANDLE;
        end else if (off_neg || len_neg) begin
          result_o.status = ST_BAD_SPAN_ARGS;
        end else if (span_oob) begin
          result_o.status = ST_SPAN_OOB;
        end else if (full) begin
          result_o.status = ST_TABLE_FULL;
        end else begin
          result_o.new_handle = HANDLE_W'(next_handle_i);
          append_o = 1'b1;
        end
      end
      ACT_CHECK: begin
        if (!hvalid) begin
          result_o.status = ST_BAD_HANDLE;
        end else if (for_write_i && ent_ro_i) begin
          result_o.status = ST_READ_ONLY;
        end else if (off_neg || len_neg || span_oob) begin
          result_o.status = ST_ACCESS_OOB;
        end else begin
          result_o.resolved_address = FIELD_W'(sum_base);
        end
      end
      default: begin
        result_o.status = ST_OK;
      end
    endcase
  end

endmodule
